@@ rtl/fcsl_pkg.sv @@
// fcsl_pkg: widths, register indexes, reset values and the pipeline control
// struct shared by the crop, shift and low-pass unit and its scaler
// depends on nothing
package fcsl_pkg;

    // field and register widths
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int DATA_W     = 40;
    localparam int N_W        = 11;
    localparam int W_W        = 10;
    localparam int RAD_W      = 20;
    localparam int NORM_W     = 32;
    localparam int IDX_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // largest transform size the row count saturates to
    localparam int MAX_SIZE = 1024;

    // register reset values
    localparam logic [N_W-1:0]    RST_ROW_COUNT  = N_W'(1024);
    localparam logic [W_W-1:0]    RST_OUT_WIDTH  = W_W'(512);
    localparam logic [RAD_W-1:0]  RST_RADIUS_SQ  = RAD_W'(524288);
    localparam logic [NORM_W-1:0] RST_NORM       = NORM_W'(4096);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT  = 2'd0,
        CFG_OUT_WIDTH  = 2'd1,
        CFG_RADIUS_SQ  = 2'd2,
        CFG_NORM       = 2'd3
    } t_cfg_idx;

    // stage load enables and the keep decision for the result stage
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic pass;
    } t_stage_ctl;

endpackage

@@ rtl/fcsl_scale.sv @@
// fcsl_scale: three-stage rounding scaler, value Q32.8 times factor Q0.32
// depends on fcsl_pkg (widths, t_stage_ctl)
module fcsl_scale
    import fcsl_pkg::*;
(
    input  logic                     i_clk,
    input  t_stage_ctl               i_ctl,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [NORM_W-1:0]        i_factor,
    output logic signed [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0]        r_mag;
    logic                     r_neg2;
    logic [DATA_W-1:0]        r_prod_hi;
    logic [2*NORM_W-1:0]      r_prod_lo;
    logic                     r_neg3;
    logic signed [DATA_W-1:0] r_result;

    logic [DATA_W-1:0]        n_mag;
    logic [DATA_W-1:0]        n_prod_hi;
    logic [2*NORM_W-1:0]      n_prod_lo;
    logic [2*NORM_W:0]        n_lo_rnd;
    logic [DATA_W:0]          n_sum;
    logic [DATA_W:0]          n_sum_neg;
    logic [DATA_W-1:0]        n_result;

    // magnitude and sign
    assign n_mag = i_value[DATA_W-1] ? (~i_value + DATA_W'(1)) : i_value;

    // partial products: upper byte and lower word of the magnitude
    assign n_prod_hi = DATA_W'(r_mag[DATA_W-1:NORM_W]) * DATA_W'(i_factor);
    assign n_prod_lo = (2*NORM_W)'(r_mag[NORM_W-1:0]) * (2*NORM_W)'(i_factor);

    // round to nearest, ties away from zero, then restore the sign
    assign n_lo_rnd  = {1'b0, r_prod_lo} + (2*NORM_W+1)'(64'h8000_0000);
    assign n_sum     = {1'b0, r_prod_hi}
                     + {{(DATA_W-NORM_W){1'b0}}, n_lo_rnd[2*NORM_W:NORM_W]};
    assign n_sum_neg = ~n_sum + (DATA_W+1)'(1);
    assign n_result  = r_neg3 ? n_sum_neg[DATA_W-1:0] : n_sum[DATA_W-1:0];

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_mag  <= n_mag;
            r_neg2 <= i_value[DATA_W-1];
        end
        if (i_ctl.ld3) begin
            r_prod_hi <= n_prod_hi;
            r_prod_lo <= n_prod_lo;
            r_neg3    <= r_neg2;
        end
        if (i_ctl.ld4) begin
            r_result <= i_ctl.pass ? $signed(n_result) : '0;
        end
    end

    assign o_value = r_result;

endmodule

@@ rtl/fourier_crop_shift_lowpass_unit.sv @@
// fourier_crop_shift_lowpass_unit: crop, row shift and radial low-pass of
// half-plane 2D FFT coefficients; depends on fcsl_pkg and fcsl_scale
//
// usage
//   input channel: i_in_valid / o_in_stall carry one coefficient
//   (i_row, i_col, i_re_in, i_im_in) per transfer
//   output channel: o_out_valid / i_out_stall carry one result
//   (o_write_valid, o_out_index, o_re_out, o_im_out) per input transfer,
//   in input order; a discarded coefficient gives write_valid 0 and zeros
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (row count, out width, radius limit, norm factor); the user must write
//   only while idle, since the block itself has no check for it
//   stages: four registers (input, index/magnitude, products, result)
//   throughput: one coefficient per cycle while the output is not stalled;
//   widest step: 32 x 32 bit product of lower magnitude word and norm factor
//   reset: pipeline emptied, registers take their reset values
//   stall: each stage holds while the next is full and blocked; input is
//   stalled only when all four stages are full and the output is stalled
module fourier_crop_shift_lowpass_unit
    import fcsl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [COL_W-1:0]          i_col,
    input  logic signed [DATA_W-1:0]  i_re_in,
    input  logic signed [DATA_W-1:0]  i_im_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_write_valid,
    output logic [IDX_W-1:0]          o_out_index,
    output logic signed [DATA_W-1:0]  o_re_out,
    output logic signed [DATA_W-1:0]  o_im_out
);

    // configuration registers
    logic [N_W-1:0]    r_row_count;
    logic [W_W-1:0]    r_out_width;
    logic [RAD_W-1:0]  r_radius_sq;
    logic [NORM_W-1:0] r_norm;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: input register
    logic [ROW_W-1:0]         r_row1;
    logic [COL_W-1:0]         r_col1;
    logic signed [DATA_W-1:0] r_re1;
    logic signed [DATA_W-1:0] r_im1;

    // stage 2: frequency indices and shifted row
    logic                     r_keep2;
    logic signed [11:0]       r_fx2, r_fy2, r_ny2;
    logic [COL_W-1:0]         r_col2;

    // stage 3: products
    logic                     r_keep3;
    logic [20:0]              r_sqx3, r_sqy3;
    logic [IDX_W-1:0]         r_prod3;
    logic [COL_W-1:0]         r_col3;

    // stage 4: result
    logic                     r_keep4;
    logic [IDX_W-1:0]         r_index4;

    logic                     ld1, ld2, ld3, ld4;
    t_stage_ctl               ctl;

    logic [N_W-1:0]           n_eff;
    logic [N_W-1:0]           n_half;
    logic signed [11:0]       n_minus_w;
    logic                     n_keep;
    logic signed [11:0]       n_fx, n_fy, n_ny;
    logic signed [23:0]       n_sqx_full, n_sqy_full, n_prod_full;
    logic [21:0]              n_d2;
    logic [IDX_W-1:0]         n_index;

    // signed frequency index of a row or column
    function automatic logic signed [11:0] freq_of(input logic [9:0] k,
                                                   input logic [N_W-1:0] n);
        logic signed [11:0] k_s;
        logic signed [11:0] n_s;
        k_s = $signed({2'b00, k});
        n_s = $signed({1'b0, n});
        if (n <= N_W'(1)) begin
            freq_of = '0;
        end else if ({1'b0, k} <= (n >> 1)) begin
            freq_of = k_s;
        end else begin
            freq_of = k_s - n_s;
        end
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RST_ROW_COUNT;
            r_out_width <= RST_OUT_WIDTH;
            r_radius_sq <= RST_RADIUS_SQ;
            r_norm      <= RST_NORM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[N_W-1:0];
                CFG_OUT_WIDTH: r_out_width <= i_cfg_data[W_W-1:0];
                CFG_RADIUS_SQ: r_radius_sq <= i_cfg_data[RAD_W-1:0];
                CFG_NORM:      r_norm      <= i_cfg_data[NORM_W-1:0];
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or its item moves on
    assign ld4 = !r_v4 || !i_out_stall;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign o_in_stall = !ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_in_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    // crop window and indices
    assign n_eff     = (r_row_count > N_W'(MAX_SIZE)) ? N_W'(MAX_SIZE) : r_row_count;
    assign n_half    = n_eff >> 1;
    assign n_minus_w = $signed({1'b0, n_eff}) - $signed({2'b00, r_out_width});
    assign n_keep    = ({1'b0, r_row1} < n_eff) && (r_col1 < r_out_width)
                    && ((r_row1 < r_out_width)
                        || ($signed({2'b00, r_row1}) >= n_minus_w));
    assign n_fx      = freq_of(r_col1, n_eff);
    assign n_fy      = freq_of(r_row1, n_eff);
    assign n_ny      = ({1'b0, r_row1} < n_half)
                     ? $signed({2'b00, r_row1} + {2'b00, r_out_width})
                     : $signed({2'b00, r_row1} - {1'b0, n_eff} + {2'b00, r_out_width});

    // squares and row offset product
    assign n_sqx_full  = r_fx2 * r_fx2;
    assign n_sqy_full  = r_fy2 * r_fy2;
    assign n_prod_full = r_ny2 * $signed({2'b00, r_out_width});

    // radius test and address
    assign n_d2    = {1'b0, r_sqx3} + {1'b0, r_sqy3};
    assign n_index = r_prod3 + {{(IDX_W-COL_W){1'b0}}, r_col3};

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_row1 <= i_row;
            r_col1 <= i_col;
            r_re1  <= i_re_in;
            r_im1  <= i_im_in;
        end
        if (ld2) begin
            r_keep2 <= n_keep;
            r_fx2   <= n_fx;
            r_fy2   <= n_fy;
            r_ny2   <= n_ny;
            r_col2  <= r_col1;
        end
        if (ld3) begin
            r_keep3 <= r_keep2;
            r_sqx3  <= n_sqx_full[20:0];
            r_sqy3  <= n_sqy_full[20:0];
            r_prod3 <= n_prod_full[IDX_W-1:0];
            r_col3  <= r_col2;
        end
        if (ld4) begin
            r_keep4  <= r_keep3;
            r_index4 <= r_keep3 ? n_index : '0;
        end
    end

    // control for the scalers
    always_comb begin
        ctl.ld2  = ld2;
        ctl.ld3  = ld3;
        ctl.ld4  = ld4;
        ctl.pass = r_keep3 && (n_d2 <= {2'b00, r_radius_sq});
    end

    fcsl_scale u_scale_re (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_value  (r_re1),
        .i_factor (r_norm),
        .o_value  (o_re_out)
    );

    fcsl_scale u_scale_im (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_value  (r_im1),
        .i_factor (r_norm),
        .o_value  (o_im_out)
    );

    assign o_out_valid   = r_v4;
    assign o_write_valid = r_keep4;
    assign o_out_index   = r_index4;

endmodule

@@ rtl/fcsl_checker.sv @@
// fcsl_checker: port-level assertions for the crop, shift and low-pass unit
// and the bind that attaches them; depends on fcsl_pkg
module fcsl_checker
    import fcsl_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_write_valid,
    input logic [IDX_W-1:0]         o_out_index,
    input logic signed [DATA_W-1:0] o_re_out,
    input logic signed [DATA_W-1:0] o_im_out
);

    // a stalled result stays offered
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_write_valid) && $stable(o_out_index)
            && $stable(o_re_out) && $stable(o_im_out))
        else $error("stalled result changed");

    // a discarded coefficient carries all-zero fields
    a_discard_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> (o_out_index == '0) && (o_re_out == '0)
            && (o_im_out == '0))
        else $error("discarded coefficient with non-zero fields");

    // input is only held back by a stalled, occupied output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind fourier_crop_shift_lowpass_unit fcsl_checker u_fcsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_write_valid (o_write_valid),
    .o_out_index   (o_out_index),
    .o_re_out      (o_re_out),
    .o_im_out      (o_im_out)
);

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for fourier_crop_shift_lowpass_unit, with a queue-fed
// coefficient driver, a result monitor and an in-bench crop/shift/low-pass predictor
// depends on fcsl_pkg and fourier_crop_shift_lowpass_unit
`timescale 1ns / 100ps

module tb_top;
    import fcsl_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [39:0] DATA_MAX     = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] DATA_MIN     = 40'h80_0000_0000;
    localparam logic [39:0] DATA_TIE     = 40'h00_0008_0000;

    // one raw coefficient and one cropped result
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } t_coef;

    typedef struct packed {
        logic              keep;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } t_coef_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [ROW_W-1:0]         i_row = '0;
    logic [COL_W-1:0]         i_col = '0;
    logic signed [DATA_W-1:0] i_re_in = '0;
    logic signed [DATA_W-1:0] i_im_in = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_write_valid;
    logic [IDX_W-1:0]         o_out_index;
    logic signed [DATA_W-1:0] o_re_out;
    logic signed [DATA_W-1:0] o_im_out;

    // register copies seen by the predictor
    logic [N_W-1:0]    cfg_rows   = RST_ROW_COUNT;
    logic [W_W-1:0]    cfg_width  = RST_OUT_WIDTH;
    logic [RAD_W-1:0]  cfg_radius = RST_RADIUS_SQ;
    logic [NORM_W-1:0] cfg_norm   = RST_NORM;

    t_coef        pending_coefs[$];
    t_coef_result expected_results[$];
    t_coef        coef_on_bus = '0;
    logic         coef_taken = 1'b0;
    logic         idle_en = 1'b1;
    int           in_gap = 0;
    int           out_gap = 0;
    int           cycle_cnt = 0;
    int           errors = 0;
    int           n_checked = 0;
    int           n_kept = 0;
    int           n_zeroed = 0;
    int           n_settings = 1;

    fourier_crop_shift_lowpass_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_re_in       (i_re_in),
        .i_im_in       (i_im_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_write_valid (o_write_valid),
        .o_out_index   (o_out_index),
        .o_re_out      (o_re_out),
        .o_im_out      (o_im_out)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // signed frequency index of a row or column
    function automatic longint freq_of(longint k, longint n);
        if (n <= 1) return 0;
        return (k <= n / 2) ? k : k - n;
    endfunction

    // v * factor / 2^32, rounded to nearest with ties away from zero
    function automatic logic [DATA_W-1:0] scale_q32(logic [DATA_W-1:0] v,
                                                    logic [NORM_W-1:0] factor);
        logic [DATA_W-1:0] mag;
        logic [63:0]       hi;
        logic [63:0]       lo;
        logic [63:0]       prod;
        mag  = v[DATA_W-1] ? (~v + 40'd1) : v;
        hi   = {56'd0, mag[39:32]};
        lo   = {32'd0, mag[31:0]};
        prod = hi * factor + ((lo * factor + 64'h8000_0000) >> 32);
        if (v[DATA_W-1]) prod = ~prod + 64'd1;
        return prod[DATA_W-1:0];
    endfunction

    // crop, row shift and radial low-pass of one coefficient
    function automatic t_coef_result predict_coef(t_coef c);
        longint       n;
        longint       w;
        longint       row;
        longint       col;
        longint       fx;
        longint       fy;
        longint       d2;
        longint       ny;
        logic [63:0]  addr;
        t_coef_result r;
        n   = (cfg_rows > MAX_SIZE) ? longint'(MAX_SIZE) : longint'(cfg_rows);
        w   = longint'(cfg_width);
        row = longint'(c.row);
        col = longint'(c.col);
        r   = '0;
        if (row < n && col < w && (row < w || row >= n - w)) begin
            fx      = freq_of(col, n);
            fy      = freq_of(row, n);
            d2      = fx * fx + fy * fy;
            ny      = (row < n / 2) ? row + w : row - n + w;
            addr    = ny * w + col;
            r.keep  = 1'b1;
            r.index = addr[IDX_W-1:0];
            if (d2 <= longint'(cfg_radius)) begin
                r.re = scale_q32(c.re, cfg_norm);
                r.im = scale_q32(c.im, cfg_norm);
            end
        end
        return r;
    endfunction

    // random sample biased towards the extremes
    function automatic logic [DATA_W-1:0] rand_sample();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return 40'(longint'($urandom_range(0, 4095)) - 2048);
            3: return $urandom_range(0, 1) ? 40'd0 : {DATA_W{1'b1}};
            default: return raw[DATA_W-1:0];
        endcase
    endfunction

    task automatic queue_coef(int unsigned row, int unsigned col,
                              logic [DATA_W-1:0] re, logic [DATA_W-1:0] im);
        t_coef c;
        c.row = ROW_W'(row);
        c.col = COL_W'(col);
        c.re  = re;
        c.im  = im;
        pending_coefs.push_back(c);
    endtask

    // mostly coefficients inside the kept band, the rest anywhere
    task automatic queue_random(int count);
        int unsigned n_eff;
        int unsigned w;
        int unsigned span;
        int unsigned row;
        int unsigned col;
        for (int i = 0; i < count; i++) begin
            n_eff = (cfg_rows > MAX_SIZE) ? MAX_SIZE : cfg_rows;
            w     = cfg_width;
            if (w > 0 && n_eff > 0 && $urandom_range(0, 3) != 0) begin
                span = (w < n_eff) ? w : n_eff;
                col  = $urandom_range(0, w - 1);
                row  = $urandom_range(0, 1) ? $urandom_range(0, span - 1)
                                            : $urandom_range(n_eff - span, n_eff - 1);
            end else begin
                row = $urandom_range(0, 1023);
                col = $urandom_range(0, 1023);
            end
            queue_coef(row, col, rand_sample(), rand_sample());
        end
    endtask

    // hold until the pipeline is empty and every result has been checked
    task automatic drain();
        @(posedge i_clk);
        while (pending_coefs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_ROW_COUNT: cfg_rows   = val[N_W-1:0];
            CFG_OUT_WIDTH: cfg_width  = val[W_W-1:0];
            CFG_RADIUS_SQ: cfg_radius = val[RAD_W-1:0];
            CFG_NORM:      cfg_norm   = val[NORM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all four registers, with junk above the width of the three narrower ones
    task automatic set_config(int unsigned rows, int unsigned wid, int unsigned rad,
                              int unsigned norm);
        write_reg(CFG_ROW_COUNT, 32'(rows) | ($urandom << N_W));
        write_reg(CFG_OUT_WIDTH, 32'(wid) | ($urandom << W_W));
        write_reg(CFG_RADIUS_SQ, 32'(rad) | ($urandom << RAD_W));
        write_reg(CFG_NORM, 32'(norm));
        n_settings++;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("fourier_crop_shift_lowpass_unit test failed");
            $finish;
        end
    end

    // input transfer: predict the result as the coefficient is taken
    always @(posedge i_clk) begin
        t_coef_result r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r = predict_coef(coef_on_bus);
            expected_results.push_back(r);
            if (r.keep) n_kept++;
            if (r.keep && r.re == '0 && r.im == '0) n_zeroed++;
            coef_taken = 1'b1;
        end
    end

    // coefficient driver with random gaps
    always @(negedge i_clk) begin
        t_coef c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || coef_taken) begin
            coef_taken = 1'b0;
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (pending_coefs.size() != 0) begin
                c           = pending_coefs.pop_front();
                coef_on_bus = c;
                i_row      <= c.row;
                i_col      <= c.col;
                i_re_in    <= c.re;
                i_im_in    <= c.im;
                i_in_valid <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall bursts
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            i_out_stall <= 1'b1;
            out_gap--;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_en && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 7);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_coef_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected (index %0d)",
                         $realtime, o_out_index);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (o_write_valid !== exp_r.keep) begin
                    $display("%0t: write_valid expected %0b got %0b",
                             $realtime, exp_r.keep, o_write_valid);
                    errors++;
                end
                if (o_out_index !== exp_r.index) begin
                    $display("%0t: out_index expected %0d got %0d",
                             $realtime, exp_r.index, o_out_index);
                    errors++;
                end
                if (o_re_out !== exp_r.re) begin
                    $display("%0t: re_out expected %0d got %0d",
                             $realtime, $signed(exp_r.re), o_re_out);
                    errors++;
                end
                if (o_im_out !== exp_r.im) begin
                    $display("%0t: im_out expected %0d got %0d",
                             $realtime, $signed(exp_r.im), o_im_out);
                    errors++;
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        int unsigned n_rand;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: band edges, discarded columns, rounding ties
        queue_coef(0, 0, DATA_MAX, DATA_MIN);
        queue_coef(0, 0, 40'd0, {DATA_W{1'b1}});
        queue_coef(1023, 511, DATA_MIN, DATA_MAX);
        queue_coef(512, 0, DATA_TIE, ~DATA_TIE + 40'd1);
        queue_coef(511, 511, DATA_TIE - 40'd1, ~DATA_TIE + 40'd2);
        queue_coef(512, 511, DATA_MAX, DATA_MAX);
        queue_coef(0, 512, DATA_MAX, DATA_MAX);
        queue_coef(1023, 1023, DATA_MIN, DATA_MIN);
        queue_coef(300, 100, rand_sample(), rand_sample());
        queue_coef(1023, 0, 40'd1, {DATA_W{1'b1}});
        queue_random(100);
        drain();

        // small transform, tight radius, largest factor
        set_config(16, 8, 40, 32'hFFFF_FFFF);
        queue_coef(8, 0, DATA_MAX, DATA_MIN);
        queue_coef(2, 6, DATA_MAX, DATA_MIN);
        queue_coef(15, 7, DATA_MAX, DATA_MAX);
        queue_coef(16, 0, DATA_MAX, DATA_MAX);
        queue_coef(7, 7, DATA_MIN, DATA_MAX);
        queue_coef(9, 3, DATA_MIN, DATA_MIN);
        queue_coef(14, 2, DATA_MIN, 40'd1);
        queue_coef(0, 8, DATA_MAX, DATA_MAX);
        queue_random(80);
        drain();

        // smallest legal sizes, zero radius and factor
        set_config(2, 1, 0, 0);
        queue_random(60);
        drain();

        // row count saturates, radius register fully set
        set_config(2047, 300, 20'hFFFFF, $urandom);
        queue_random(80);
        drain();

        // row counts below two
        set_config(1, 4, 0, $urandom);
        queue_random(50);
        drain();
        set_config(0, 5, $urandom_range(0, 1000), $urandom);
        queue_random(40);
        drain();

        // zero width discards everything
        set_config(8, 0, 100, $urandom);
        queue_random(40);
        drain();

        // width beyond half the rows, wrapped addresses
        set_config(8, 10, 200, $urandom);
        queue_random(70);
        drain();

        set_config(100, 37, $urandom_range(0, 5000), $urandom);
        queue_random(80);
        drain();

        // typical use: squared radius N*N/4, factor 1/(N*N)
        set_config(64, 32, 1024, 32'h0010_0000);
        queue_random(80);
        drain();

        n_rand = $urandom_range(2, 1024);
        set_config(n_rand, $urandom_range(1, n_rand / 2), $urandom_range(0, 524288),
                   $urandom);
        queue_random(100);
        drain();

        // back-to-back transfers at full rate
        idle_en = 1'b0;
        n_rand  = $urandom_range(2, 256);
        set_config(n_rand, $urandom_range(1, n_rand), $urandom_range(0, 20000), $urandom);
        queue_random(150);
        drain();

        $display("checked %0d results over %0d register settings", n_checked, n_settings);
        $display("%0d coefficients kept, %0d of them zero after scaling or the radius cut",
                 n_kept, n_zeroed);
        if (errors == 0)
            $display("fourier_crop_shift_lowpass_unit test passed");
        else
            $display("fourier_crop_shift_lowpass_unit test failed");
        $finish;
    end

endmodule
